// ===== rtl/rto_pkg.sv =====
package rto_pkg;

    localparam int NUM_STATES = 16;
    localparam int IDX_W      = 4;
    localparam int KEY_W      = 4;

    typedef logic [NUM_STATES-1:0] row_t;
    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [KEY_W-1:0]      key_t;

    // phase strobes broadcast from the sequencer to every lane
    typedef struct packed {
        logic build;
        logic close;
        logic count;
        idx_t k;
    } lane_ctrl_t;

    // what the merge stage reports back for the current key
    typedef struct packed {
        logic hit;
        idx_t idx;
        logic is_last;
    } merge_res_t;

endpackage

// ===== rtl/reachability_topological_order.sv =====
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata row_index, edge_bits; tuser is_member; tlast last_row
// m_*      out  m_tvalid/m_tready  tdata state_index; tlast last_state
// cfg_*    in   cfg_we             cfg_wdata background_state
//
// Rows load one item per cycle, back to back, into the per-row lanes.
// After the tlast row: a build step, the closure sweep (one Warshall pivot per step) and a key
// count step, then the merge emits members in key order, stepping past keys with no match.
// s_tready drops after the tlast row and rises once the emit state finds no member left and returns to idle.
// m_tready low holds a valid output register and stalls the merge at the next matching member.
// aresetn (sync, active low) clears control and member mask; background_state resets to 1.
module reachability_topological_order (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // row_index[3:0], edge_bits[19:4], zero pad
    input  logic        s_tuser,   // is_member
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // state_index[3:0], zero pad
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata
);
    import rto_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BUILD = 3'd1;
    localparam logic [2:0] ST_CLOSE = 3'd2;
    localparam logic [2:0] ST_COUNT = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;
    localparam idx_t       K_LAST   = idx_t'(NUM_STATES - 1);
    localparam key_t       KEY_LAST = key_t'(NUM_STATES - 1);

    logic [2:0] state_reg, state_next;
    idx_t       k_reg, k_next;
    key_t       cur_key_reg, cur_key_next;
    row_t       mask_reg, mask_next;
    row_t       pending_reg, pending_next;
    idx_t       bg_reg;
    logic       m_valid_reg, m_valid_next;
    idx_t       m_idx_reg, m_idx_next;
    logic       m_last_reg, m_last_next;

    logic       s_fire;
    idx_t       in_row;
    row_t       in_bits;
    logic       out_free;
    logic       emit_fire;

    lane_ctrl_t ctrl;
    row_t       edge_rows    [NUM_STATES];
    row_t       closure_rows [NUM_STATES];
    row_t       columns      [NUM_STATES];
    key_t [NUM_STATES-1:0] keys;
    row_t       init_set;
    merge_res_t mres;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_row   = s_tdata[IDX_W-1:0];
    assign in_bits  = s_tdata[IDX_W +: NUM_STATES];

    assign ctrl.build = (state_reg == ST_BUILD);
    assign ctrl.close = (state_reg == ST_CLOSE);
    assign ctrl.count = (state_reg == ST_COUNT);
    assign ctrl.k     = k_reg;

    // background row: members it points at are initial
    assign init_set = edge_rows[bg_reg] & mask_reg;

    // column y of the closure = who reaches y
    always_comb begin
        for (int y = 0; y < NUM_STATES; y++) begin
            for (int x = 0; x < NUM_STATES; x++) begin
                columns[y][x] = closure_rows[x][y];
            end
        end
    end

    for (genvar g = 0; g < NUM_STATES; g++) begin : g_lane
        rto_lane u_lane (
            .aclk        (aclk),
            .lane_id     (idx_t'(g)),
            .ctrl        (ctrl),
            .wr_en       (s_fire),
            .wr_row      (in_row),
            .wr_data     (in_bits),
            .mask        (mask_reg),
            .bg          (bg_reg),
            .init_set    (init_set),
            .row_k       (closure_rows[k_reg]),
            .column      (columns[g]),
            .edge_row    (edge_rows[g]),
            .closure_row (closure_rows[g]),
            .key         (keys[g])
        );
    end

    rto_merge u_merge (
        .pending (pending_reg),
        .keys    (keys),
        .cur_key (cur_key_reg),
        .res     (mres)
    );

    assign out_free  = !m_valid_reg || m_tready;
    assign emit_fire = (state_reg == ST_EMIT) && mres.hit && out_free;

    always_comb begin
        state_next   = state_reg;
        k_next       = k_reg;
        cur_key_next = cur_key_reg;
        mask_next    = mask_reg;
        pending_next = pending_reg;
        m_valid_next = m_valid_reg;
        m_idx_next   = m_idx_reg;
        m_last_next  = m_last_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    mask_next[in_row] = s_tuser;
                    if (s_tlast) begin
                        state_next = ST_BUILD;
                    end
                end
            end
            ST_BUILD: begin
                k_next     = '0;
                state_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                k_next = k_reg + 1'b1;
                if (k_reg == K_LAST) begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT: begin
                pending_next = mask_reg;
                cur_key_next = '0;
                state_next   = ST_EMIT;
            end
            ST_EMIT: begin
                if (pending_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (mres.hit) begin
                    if (out_free) begin
                        m_valid_next              = 1'b1;
                        m_idx_next                = mres.idx;
                        m_last_next               = mres.is_last;
                        pending_next[mres.idx]    = 1'b0;
                    end
                end else if (cur_key_reg == KEY_LAST) begin
                    state_next = ST_IDLE;
                end else begin
                    cur_key_next = cur_key_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mask_reg    <= '0;
            bg_reg      <= idx_t'(1);
            m_valid_reg <= 1'b0;
            pending_reg <= '0;
        end else begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
            pending_reg <= pending_next;
            if (cfg_we) begin
                bg_reg <= cfg_wdata;
            end
        end
        k_reg       <= k_next;
        cur_key_reg <= cur_key_next;
        m_idx_reg   <= m_idx_next;
        m_last_reg  <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(8 - IDX_W){1'b0}}, m_idx_reg};
    assign m_tlast  = m_last_reg;

    // only members are ever queued for output
    a_pending_members: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> ((pending_reg & ~mask_reg) == '0))
        else $error("pending holds a non-member");

    // emitting the item flagged last drains the queue
    a_last_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_fire && mres.is_last) |=> (pending_reg == '0))
        else $error("last item emitted with members still pending");

    // the closure sweep covers every pivot before the count
    a_full_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COUNT) |-> ($past(state_reg) == ST_CLOSE && $past(k_reg) == K_LAST))
        else $error("closure sweep cut short");

    // no input taken while an order is in progress
    a_no_input_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && pending_reg != '0) |-> !s_fire)
        else $error("input accepted during emit");

endmodule

// ===== rtl/rto_lane.sv =====
module rto_lane (
    input  logic               aclk,
    input  rto_pkg::idx_t      lane_id,
    input  rto_pkg::lane_ctrl_t ctrl,
    input  logic               wr_en,
    input  rto_pkg::idx_t      wr_row,
    input  rto_pkg::row_t      wr_data,
    input  rto_pkg::row_t      mask,
    input  rto_pkg::idx_t      bg,
    input  rto_pkg::row_t      init_set,
    input  rto_pkg::row_t      row_k,
    input  rto_pkg::row_t      column,
    output rto_pkg::row_t      edge_row,
    output rto_pkg::row_t      closure_row,
    output rto_pkg::key_t      key
);
    import rto_pkg::*;

    row_t edge_reg;
    row_t closure_reg;
    row_t closure_next;
    key_t key_reg;
    row_t self_bit;
    row_t reach_bits;
    logic is_final;

    assign self_bit   = row_t'(1) << lane_id;
    assign is_final   = mask[lane_id] & edge_reg[bg];
    assign reach_bits = column & mask & ~self_bit;

    always_comb begin
        closure_next = closure_reg;
        if (ctrl.build) begin
            if (mask[lane_id]) begin
                closure_next = edge_reg & mask & (is_final ? ~init_set : '1);
            end else begin
                closure_next = '0;
            end
        end else if (ctrl.close && closure_reg[ctrl.k]) begin
            closure_next = closure_reg | row_k;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en && wr_row == lane_id) begin
            edge_reg <= wr_data;
        end
        closure_reg <= closure_next;
        if (ctrl.count) begin
            key_reg <= KEY_W'($countones(reach_bits));
        end
    end

    assign edge_row    = edge_reg;
    assign closure_row = closure_reg;
    assign key         = key_reg;

endmodule

// ===== rtl/rto_merge.sv =====
module rto_merge (
    input  rto_pkg::row_t                        pending,
    input  rto_pkg::key_t [rto_pkg::NUM_STATES-1:0] keys,
    input  rto_pkg::key_t                        cur_key,
    output rto_pkg::merge_res_t                  res
);
    import rto_pkg::*;

    row_t match;

    always_comb begin
        for (int i = 0; i < NUM_STATES; i++) begin
            match[i] = pending[i] && (keys[i] == cur_key);
        end
    end

    // lowest matching index wins
    always_comb begin
        res.hit     = |match;
        res.idx     = '0;
        res.is_last = ($countones(pending) == 1);
        for (int i = NUM_STATES - 1; i >= 0; i--) begin
            if (match[i]) begin
                res.idx = IDX_W'(i);
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rto_pkg::*;

    localparam int SETTLE_CYCLES = 64;    // covers build, closure sweep, count and worst merge, with margin
    localparam int STALL_LIMIT   = 2000;  // cycles without any handshake before giving up
    localparam int PHASE_ITEMS   = 33;

    typedef struct packed {
        idx_t state;
        logic last;
    } order_entry_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // row_index[3:0], edge_bits[19:4], zero pad
    logic        s_tuser;   // is_member
    logic        s_tlast;   // last_row
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;   // state_index[3:0], zero pad
    logic        m_tlast;   // last_state
    logic        cfg_we;
    logic [3:0]  cfg_wdata; // background_state

    // shadow copy of the block's graph state
    row_t         graph_rows [NUM_STATES];
    row_t         member_set;
    idx_t         bg_shadow;
    order_entry_t order_q[$];
    order_entry_t got_exp;

    int src_idle_pct = 33;
    int dst_idle_pct = 86;
    int err_cnt      = 0;
    int items_sent   = 0;
    int stall_cycles = 0;

    reachability_topological_order u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #10 aclk = ~aclk;

    // Expected order of the members: classify against the background state,
    // prune final->initial edges, Warshall closure, then sort by in-reach count.
    task automatic predict_order();
        row_t init_set;
        row_t final_set;
        row_t reach [NUM_STATES];
        int   in_reach [NUM_STATES];
        int   total;
        int   emitted;
        init_set  = graph_rows[bg_shadow] & member_set;
        final_set = '0;
        for (int i = 0; i < NUM_STATES; i++)
            if (member_set[i] && graph_rows[i][bg_shadow])
                final_set[i] = 1'b1;
        for (int i = 0; i < NUM_STATES; i++) begin
            reach[i] = '0;
            if (member_set[i]) begin
                reach[i] = graph_rows[i] & member_set;
                if (final_set[i])
                    reach[i] &= ~init_set;
            end
        end
        for (int k = 0; k < NUM_STATES; k++)
            for (int i = 0; i < NUM_STATES; i++)
                if (reach[i][k])
                    reach[i] |= reach[k];
        // self reach on a cycle does not count toward a state's own key
        for (int y = 0; y < NUM_STATES; y++) begin
            in_reach[y] = 0;
            for (int x = 0; x < NUM_STATES; x++)
                if (x != y && member_set[x] && reach[x][y])
                    in_reach[y]++;
        end
        total   = $countones(member_set);
        emitted = 0;
        for (int key = 0; key < NUM_STATES; key++)
            for (int i = 0; i < NUM_STATES; i++)
                if (member_set[i] && in_reach[i] == key) begin
                    emitted++;
                    order_q.push_back('{idx_t'(i), emitted == total});
                end
    endtask

    task automatic update_graph(input idx_t row, input row_t bits, input logic member,
                                input logic last);
        graph_rows[row] = bits;
        member_set[row] = member;
        if (last)
            predict_order();
    endtask

    // One row item; s_tvalid stays high into the next item unless the sender idles.
    task automatic send_row(input idx_t row, input row_t bits, input logic member,
                            input logic last);
        if ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, bits, row};
        s_tuser  <= member;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        update_graph(row, bits, member, last);
    endtask

    // Drop valid, let every expected result drain, then give the block time
    // to finish an ordering that produced nothing.
    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (order_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_background(input idx_t value);
        wait_quiet();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        bg_shadow = value;
    endtask

    // Load every row once with no members; the last row orders an empty set.
    // Afterwards no row of the block is ever unwritten.
    task automatic test_empty_set();
        for (int r = 0; r < NUM_STATES; r++)
            send_row(idx_t'(r), r[0] ? 16'hFFFF : 16'h0000, 1'b0, r == NUM_STATES - 1);
    endtask

    // Background 1 (reset value) reaches 2 and 6, so both are initial.
    // 6 has an edge back to 1 (final), so its edge to 2 is dropped.
    // 2 and 3 form a cycle; self reach must not raise their keys.
    task automatic test_classify_and_cycle();
        send_row(4'd1, 16'h0044, 1'b0, 1'b0);
        send_row(4'd2, 16'h0008, 1'b1, 1'b0);
        send_row(4'd3, 16'h0004, 1'b1, 1'b0);
        send_row(4'd7, 16'h0000, 1'b1, 1'b0);
        send_row(4'd6, 16'h0086, 1'b1, 1'b1);
    endtask

    // Full edge rows at both ends of the index range; the state kept from the
    // previous test is ordered again.
    task automatic test_full_rows();
        send_row(4'd0,  16'hFFFF, 1'b1, 1'b0);
        send_row(4'd15, 16'hFFFF, 1'b1, 1'b1);
    endtask

    // A frame is a run of rows closed by last_row; sometimes it rewrites every row.
    task automatic send_random_frame();
        int   n;
        bit   full;
        idx_t row;
        row_t bits;
        full = ($urandom_range(4) == 0);
        n    = full ? NUM_STATES : $urandom_range(1, 6);
        for (int r = 0; r < n; r++) begin
            row = full ? idx_t'(r) : idx_t'($urandom_range(NUM_STATES - 1));
            case ($urandom_range(3))
                0: bits = row_t'($urandom) & row_t'($urandom);
                1: bits = row_t'($urandom);
                2: bits = row_t'($urandom) & (row_t'('1) << (row + 1));  // acyclic
                default: bits = row_t'($urandom_range(1)) << bg_shadow;
            endcase
            send_row(row, bits, $urandom_range(99) < 70, r == n - 1);
        end
    endtask

    task automatic test_random_phase(input int src_pct, input int dst_pct, input idx_t bg);
        int start;
        write_background(bg);
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
            send_random_frame();
    endtask

    // Result side: random back-pressure and in-order compare.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= dst_idle_pct);
        if (m_tvalid && m_tready) begin
            if (order_q.size() == 0) begin
                $display("%0t: unexpected item state_index=%0d last_state=%0b",
                         $time, m_tdata[IDX_W-1:0], m_tlast);
                err_cnt++;
            end else begin
                got_exp = order_q.pop_front();
                if (m_tdata[IDX_W-1:0] !== got_exp.state) begin
                    $display("%0t: state_index expected %0d actual %0d",
                             $time, got_exp.state, m_tdata[IDX_W-1:0]);
                    err_cnt++;
                end
                if (m_tlast !== got_exp.last) begin
                    $display("%0t: last_state expected %0b actual %0b",
                             $time, got_exp.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: any handshake on either side restarts the count.
    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        member_set = '0;
        bg_shadow  = 4'd1;
        for (int r = 0; r < NUM_STATES; r++)
            graph_rows[r] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_set();
        test_classify_and_cycle();
        test_full_rows();

        test_random_phase(33, 86, 4'd0);
        test_random_phase(86, 33, 4'd15);
        test_random_phase(0, 0, idx_t'($urandom_range(NUM_STATES - 1)));

        wait_quiet();
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== reachability_topological_order.f =====
rtl/rto_pkg.sv
rtl/rto_lane.sv
rtl/rto_merge.sv
rtl/reachability_topological_order.sv
sim/tb_top.sv
